// File: src/hbe_pkg.sv
// Shared types and constants for the static Huffman byte encoder.
// Used by the controller, the datapath and the top level; no dependencies.
package hbe_pkg;

  localparam int SYMBOLS     = 256;
  localparam int NODES       = 511;
  localparam int COUNT_BITS  = 32;
  localparam int WEIGHT_BITS = 40;
  localparam int MAX_CODE    = SYMBOLS - 1;
  localparam int INNER       = NODES - SYMBOLS;
  localparam int SYM_BITS    = $clog2(SYMBOLS);
  localparam int NODE_BITS   = $clog2(NODES);
  localparam int PAR_BITS    = 10;
  localparam int LEN_BITS    = 8;
  localparam int BYTE_BITS   = 8;

  localparam logic [PAR_BITS-1:0] NO_NODE = '1;

  typedef enum logic [1:0] {
    CMD_COUNT  = 2'd0,
    CMD_BUILD  = 2'd1,
    CMD_ENCODE = 2'd2
  } cmd_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic cnt_rd;
    logic cnt_wr;
    logic leaf_iss;
    logic scan_init;
    logic scan_iss;
    logic mrg1;
    logic mrg2;
    logic mrg3;
    logic gen0;
    logic gen1;
    logic gen2;
    logic gen_st;
    logic enc_ld;
    logic enc_bit;
    logic fin1;
    logic fin2;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic leaf_last;
    logic scan_last;
    logic merge_last;
    logic par_none;
    logic gen_last;
    logic elen_zero;
  } stat_t;

endpackage

// File: src/huffman_byte_encoder.sv
// Static Huffman byte encoder: count, build and encode commands on one port.
// Count reads then writes the count memory; encode loads the code and packs it bit
// by bit, a full word held until the next one fills or the encode ends; build sweeps
// the leaves, makes 255 merges by scanning the live nodes, then walks each code.
// One command at a time; results cannot be stalled. Reset (async, low) clears
// counts, codes and the partial word; no clearing pass is needed.
module huffman_byte_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] command_i,
  input  logic [7:0] symbol_i,
  input  logic       end_of_text_i,
  output logic       result_valid_o,
  output logic [7:0] packed_byte_o,
  output logic       last_of_run_o
);

  hbe_pkg::ctl_t  ctl;
  hbe_pkg::stat_t stat;

  // Controller.
  hbe_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .stat_i    (stat),
    .ctl_o     (ctl),
    .busy      (busy)
  );

  // Datapath.
  hbe_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .symbol_i       (symbol_i),
    .end_of_text_i  (end_of_text_i),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .packed_byte_o  (packed_byte_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

// File: src/hbe_ctrl.sv
// Sequencing state machine of the Huffman byte encoder.
// Depends on hbe_pkg for the command and status structs.
module hbe_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic [1:0]     command_i,
  input  hbe_pkg::stat_t stat_i,
  output hbe_pkg::ctl_t  ctl_o,
  output logic           busy
);

  typedef enum logic [18:0] {
    S_IDLE    = 19'h00001,
    S_CNT_RD  = 19'h00002,
    S_CNT_WR  = 19'h00004,
    S_LEAF    = 19'h00008,
    S_LEAF_DR = 19'h00010,
    S_SCAN    = 19'h00020,
    S_SCAN_DR = 19'h00040,
    S_MRG1    = 19'h00080,
    S_MRG2    = 19'h00100,
    S_MRG3    = 19'h00200,
    S_GEN0    = 19'h00400,
    S_GEN1    = 19'h00800,
    S_GEN2    = 19'h01000,
    S_GEN_ST  = 19'h02000,
    S_ENC_RD  = 19'h04000,
    S_ENC_LD  = 19'h08000,
    S_ENC_BIT = 19'h10000,
    S_FIN1    = 19'h20000,
    S_FIN2    = 19'h40000
  } state_e;

  state_e state_q, state_d;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (command_i)
            hbe_pkg::CMD_COUNT:  state_d = S_CNT_RD;
            hbe_pkg::CMD_BUILD:  state_d = S_LEAF;
            hbe_pkg::CMD_ENCODE: state_d = S_ENC_RD;
            default:             state_d = S_IDLE;
          endcase
        end
      end
      S_CNT_RD:  state_d = S_CNT_WR;
      S_CNT_WR:  state_d = S_IDLE;
      S_LEAF:    if (stat_i.leaf_last) state_d = S_LEAF_DR;
      S_LEAF_DR: state_d = S_SCAN;
      S_SCAN:    if (stat_i.scan_last) state_d = S_SCAN_DR;
      S_SCAN_DR: state_d = S_MRG1;
      S_MRG1:    state_d = S_MRG2;
      S_MRG2:    state_d = S_MRG3;
      S_MRG3:    state_d = stat_i.merge_last ? S_GEN0 : S_SCAN;
      S_GEN0:    state_d = S_GEN1;
      S_GEN1:    state_d = stat_i.par_none ? S_GEN_ST : S_GEN2;
      S_GEN2:    state_d = S_GEN1;
      S_GEN_ST:  state_d = stat_i.gen_last ? S_IDLE : S_GEN0;
      S_ENC_RD:  state_d = S_ENC_LD;
      S_ENC_LD:  state_d = S_ENC_BIT;
      S_ENC_BIT: if (stat_i.elen_zero) state_d = S_FIN1;
      S_FIN1:    state_d = S_FIN2;
      S_FIN2:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath commands decoded from the state.
  always_comb begin
    ctl_o           = '0;
    ctl_o.latch     = (state_q == S_IDLE) && start;
    ctl_o.cnt_rd    = (state_q == S_CNT_RD);
    ctl_o.cnt_wr    = (state_q == S_CNT_WR);
    ctl_o.leaf_iss  = (state_q == S_LEAF);
    ctl_o.scan_init = (state_q == S_LEAF_DR) || (state_q == S_MRG3);
    ctl_o.scan_iss  = (state_q == S_SCAN);
    ctl_o.mrg1      = (state_q == S_MRG1);
    ctl_o.mrg2      = (state_q == S_MRG2);
    ctl_o.mrg3      = (state_q == S_MRG3);
    ctl_o.gen0      = (state_q == S_GEN0);
    ctl_o.gen1      = (state_q == S_GEN1);
    ctl_o.gen2      = (state_q == S_GEN2);
    ctl_o.gen_st    = (state_q == S_GEN_ST);
    ctl_o.enc_ld    = (state_q == S_ENC_LD);
    ctl_o.enc_bit   = (state_q == S_ENC_BIT);
    ctl_o.fin1      = (state_q == S_FIN1);
    ctl_o.fin2      = (state_q == S_FIN2);
  end

  assign busy = (state_q != S_IDLE);

  // A started build always walks the whole leaf sweep first.
  a_build_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start && command_i == hbe_pkg::CMD_BUILD) |=> state_q == S_LEAF)
    else $error("build did not enter leaf sweep");
  // A merge is always followed by the next scan or by code generation.
  a_merge_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MRG3) |=> (state_q == S_SCAN || state_q == S_GEN0))
    else $error("bad exit from merge");
  // Flushing always ends the encode sequence.
  a_fin_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN2) |=> !busy)
    else $error("encode did not finish after flush");

endmodule

// File: src/hbe_datapath.sv
// Memories, merge scan, code walk and bit packer of the Huffman byte encoder.
// Depends on hbe_pkg; driven by hbe_ctrl through ctl_t and stat_t.
module hbe_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hbe_pkg::ctl_t  ctl_i,
  input  logic [7:0]     symbol_i,
  input  logic           end_of_text_i,
  output hbe_pkg::stat_t stat_o,
  output logic           result_valid_o,
  output logic [7:0]     packed_byte_o,
  output logic           last_of_run_o
);

  localparam int SB = hbe_pkg::SYM_BITS;
  localparam int NB = hbe_pkg::NODE_BITS;
  localparam int PB = hbe_pkg::PAR_BITS;
  localparam int WB = hbe_pkg::WEIGHT_BITS;
  localparam int CB = hbe_pkg::COUNT_BITS;
  localparam int LB = hbe_pkg::LEN_BITS;
  localparam int MC = hbe_pkg::MAX_CODE;

  // Storage.
  logic [CB-1:0] cnt_mem  [hbe_pkg::SYMBOLS];
  logic [hbe_pkg::SYMBOLS-1:0] cnt_vld_q;
  logic [WB-1:0] wgt_mem  [hbe_pkg::NODES];
  logic [PB-1:0] par_mem  [hbe_pkg::NODES];
  logic [NB-1:0] sec_mem  [hbe_pkg::INNER];
  logic [MC-1:0] code_mem [hbe_pkg::SYMBOLS];
  logic [LB-1:0] len_mem  [hbe_pkg::SYMBOLS];

  // Registered read data.
  logic [CB-1:0] cnt_rd_q;
  logic          cnt_rv_q;
  logic [WB-1:0] wgt_rd_q;
  logic [PB-1:0] par_rd_q;
  logic [NB-1:0] sec_rd_q;
  logic [MC-1:0] code_rd_q;
  logic [LB-1:0] len_rd_q;

  // Working registers.
  logic [SB-1:0] sym_q;
  logic          eot_q;
  logic [NB-1:0] idx_q, idx_d1_q;
  logic [NB-1:0] next_q;
  logic          leaf_v_q, cmp_v_q;
  logic [NB-1:0] min1_q, min2_q;
  logic [WB-1:0] w1_q, w2_q;
  logic          have1_q, have2_q;
  logic [NB-1:0] cur_q;
  logic [PB-1:0] par_q;
  logic [LB-1:0] len_q;
  logic [MC-1:0] rev_q;
  logic [MC-1:0] code_q;
  logic [LB-1:0] elen_q;
  logic          built_q;
  logic [6:0]    pend_bits_q;
  logic [2:0]    pend_cnt_q;
  logic [7:0]    held_q;
  logic          held_v_q;
  logic          out_v_q, out_last_q;
  logic [7:0]    out_byte_q;

  logic [SB-1:0] cnt_addr;
  logic [CB-1:0] cnt_cur;
  logic [NB-1:0] par_raddr;
  logic [NB-1:0] wgt_waddr, par_waddr;
  logic [WB-1:0] wgt_wdata;
  logic [PB-1:0] par_wdata;
  logic          wgt_we, par_we;
  logic          live;
  logic          code_bit;
  logic [7:0]    acc;
  logic          flush;
  logic [7:0]    pad_byte;

  // Count memory: read-modify-write for counting, swept for the leaves.
  assign cnt_addr = ctl_i.cnt_rd ? sym_q : idx_q[SB-1:0];
  assign cnt_cur  = cnt_rv_q ? cnt_rd_q : '0;

  always_ff @(posedge clk_i) begin
    cnt_rd_q <= cnt_mem[cnt_addr];
    if (ctl_i.cnt_wr) begin
      cnt_mem[sym_q] <= (cnt_cur == '1) ? cnt_cur : cnt_cur + CB'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
      cnt_rv_q  <= 1'b0;
    end else begin
      cnt_rv_q <= cnt_vld_q[cnt_addr];
      if (ctl_i.cnt_wr) begin
        cnt_vld_q[sym_q] <= 1'b1;
      end
    end
  end

  // Node weight and parent write selection.
  always_comb begin
    wgt_we    = 1'b0;
    wgt_waddr = idx_d1_q;
    wgt_wdata = WB'(cnt_cur);
    par_we    = 1'b0;
    par_waddr = idx_d1_q;
    par_wdata = hbe_pkg::NO_NODE;
    if (leaf_v_q) begin
      wgt_we = 1'b1;
      par_we = 1'b1;
    end else if (ctl_i.mrg1) begin
      par_we    = 1'b1;
      par_waddr = min1_q;
      par_wdata = PB'(next_q);
    end else if (ctl_i.mrg2) begin
      par_we    = 1'b1;
      par_waddr = min2_q;
      par_wdata = PB'(next_q);
    end else if (ctl_i.mrg3) begin
      wgt_we    = 1'b1;
      wgt_waddr = next_q;
      wgt_wdata = w1_q + w2_q;
      par_we    = 1'b1;
      par_waddr = next_q;
    end
  end

  assign par_raddr = ctl_i.gen2 ? par_q[NB-1:0] : idx_q;

  // Node tables: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    wgt_rd_q <= wgt_mem[idx_q];
    par_rd_q <= par_mem[par_raddr];
    sec_rd_q <= sec_mem[par_rd_q[SB-1:0]];
    if (wgt_we) begin
      wgt_mem[wgt_waddr] <= wgt_wdata;
    end
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    if (ctl_i.mrg2) begin
      sec_mem[next_q[SB-1:0]] <= min2_q;
    end
  end

  // Code table, written once per symbol by the walk.
  always_ff @(posedge clk_i) begin
    code_rd_q <= code_mem[sym_q];
    len_rd_q  <= len_mem[sym_q];
    if (ctl_i.gen_st) begin
      code_mem[idx_q[SB-1:0]] <= rev_q;
      len_mem[idx_q[SB-1:0]]  <= len_q;
    end
  end

  // Index, scan pipeline and two-lightest tracking.
  assign live = (par_rd_q == hbe_pkg::NO_NODE);

  always_ff @(posedge clk_i) begin
    idx_d1_q <= idx_q;
    if (ctl_i.latch) begin
      sym_q  <= symbol_i;
      eot_q  <= end_of_text_i;
      idx_q  <= '0;
      next_q <= NB'(hbe_pkg::SYMBOLS);
    end else if (ctl_i.leaf_iss || ctl_i.scan_iss || ctl_i.gen_st) begin
      idx_q <= idx_q + NB'(1);
    end else if (ctl_i.scan_init) begin
      idx_q <= '0;
    end
    if (ctl_i.mrg3) begin
      next_q <= next_q + NB'(1);
    end
    if (ctl_i.scan_init) begin
      have1_q <= 1'b0;
      have2_q <= 1'b0;
    end else if (cmp_v_q && live) begin
      if (!have1_q || wgt_rd_q < w1_q) begin
        min2_q  <= min1_q;
        w2_q    <= w1_q;
        have2_q <= have1_q;
        min1_q  <= idx_d1_q;
        w1_q    <= wgt_rd_q;
        have1_q <= 1'b1;
      end else if (!have2_q || wgt_rd_q < w2_q) begin
        min2_q  <= idx_d1_q;
        w2_q    <= wgt_rd_q;
        have2_q <= 1'b1;
      end
    end
  end

  // Root-ward walk that collects each symbol's code, leaf end first.
  always_ff @(posedge clk_i) begin
    if (ctl_i.gen0) begin
      cur_q <= idx_q;
      len_q <= '0;
      rev_q <= '0;
    end
    if (ctl_i.gen1) begin
      par_q <= par_rd_q;
    end
    if (ctl_i.gen2) begin
      rev_q[len_q] <= (sec_rd_q == cur_q);
      len_q        <= len_q + LB'(1);
      cur_q        <= par_q[NB-1:0];
    end
  end

  // Bit packer.
  assign code_bit = code_q[elen_q - LB'(1)];
  assign acc      = {pend_bits_q, code_bit};
  assign flush    = eot_q && (pend_cnt_q != 3'd0);
  assign pad_byte = 8'({1'b0, pend_bits_q} << (4'd8 - {1'b0, pend_cnt_q}));

  always_ff @(posedge clk_i) begin
    if (ctl_i.enc_ld) begin
      code_q <= code_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_v_q    <= 1'b0;
      cmp_v_q     <= 1'b0;
      built_q     <= 1'b0;
      elen_q      <= '0;
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      held_q      <= '0;
      held_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
      out_last_q  <= 1'b0;
      out_byte_q  <= '0;
    end else begin
      leaf_v_q <= ctl_i.leaf_iss;
      cmp_v_q  <= ctl_i.scan_iss;
      out_v_q  <= 1'b0;
      if (ctl_i.gen_st) begin
        built_q <= 1'b1;
      end
      if (ctl_i.enc_ld) begin
        elen_q <= built_q ? len_rd_q : '0;
      end
      // Push one code bit; a full word waits in the holding register.
      if (ctl_i.enc_bit && (elen_q != '0)) begin
        elen_q <= elen_q - LB'(1);
        if (pend_cnt_q == 3'd7) begin
          if (held_v_q) begin
            out_v_q    <= 1'b1;
            out_byte_q <= held_q;
            out_last_q <= 1'b0;
          end
          held_q      <= acc;
          held_v_q    <= 1'b1;
          pend_bits_q <= '0;
          pend_cnt_q  <= '0;
        end else begin
          pend_bits_q <= acc[6:0];
          pend_cnt_q  <= pend_cnt_q + 3'd1;
        end
      end
      // Release the held word, marked last unless a padded word follows.
      if (ctl_i.fin1 && held_v_q) begin
        out_v_q    <= 1'b1;
        out_byte_q <= held_q;
        out_last_q <= !flush;
        held_v_q   <= 1'b0;
      end
      // Pad and flush the partial word.
      if (ctl_i.fin2 && flush) begin
        out_v_q     <= 1'b1;
        out_byte_q  <= pad_byte;
        out_last_q  <= 1'b1;
        pend_bits_q <= '0;
        pend_cnt_q  <= '0;
      end
    end
  end

  // Status back to the controller.
  assign stat_o.leaf_last  = (idx_q == NB'(hbe_pkg::SYMBOLS - 1));
  assign stat_o.scan_last  = (idx_q == next_q - NB'(1));
  assign stat_o.merge_last = (next_q == NB'(hbe_pkg::NODES - 1));
  assign stat_o.par_none   = live;
  assign stat_o.gen_last   = (idx_q == NB'(hbe_pkg::SYMBOLS - 1));
  assign stat_o.elen_zero  = (elen_q == '0);

  assign result_valid_o = out_v_q;
  assign packed_byte_o  = out_byte_q;
  assign last_of_run_o  = out_last_q;

  // Every merge joins two distinct live nodes.
  a_two_nodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.mrg1 |-> (have1_q && have2_q && min1_q != min2_q))
    else $error("merge without two distinct nodes");
  // After end of text the partial word is empty.
  a_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.fin2 && eot_q) |=> (pend_cnt_q == 3'd0))
    else $error("partial word left after flush");
  // The held word is always released before the encode ends.
  a_held_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.fin2 |-> !held_v_q)
    else $error("held word not released");

endmodule

// File: sim/huffman_byte_encoder_tb.sv
// Self-checking testbench for huffman_byte_encoder: counts, builds and encodes bytes
// and checks every packed output word against a built-in Huffman coder.
// Depends on hbe_pkg and the huffman_byte_encoder RTL.
module huffman_byte_encoder_tb;

  // Command code 3 is not in the package enum; the block must ignore it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [7:0] word;
    logic       last;
  } packed_word_t;

  // Scoreboard: keeps its own copy of the encoder state and the expected words.
  class huffman_scoreboard;
    logic [hbe_pkg::COUNT_BITS-1:0]  freq[hbe_pkg::SYMBOLS];
    logic [hbe_pkg::WEIGHT_BITS-1:0] weight[hbe_pkg::NODES];
    int                              parent[hbe_pkg::NODES];
    int                              first_child[hbe_pkg::NODES];
    int                              second_child[hbe_pkg::NODES];
    bit [hbe_pkg::MAX_CODE-1:0]      code[hbe_pkg::SYMBOLS];
    int                              code_len[hbe_pkg::SYMBOLS];
    logic [6:0]                      acc_bits;
    int                              acc_count;
    packed_word_t                    expected_words[$];
    int                              mismatches;

    function void clear();
      for (int s = 0; s < hbe_pkg::SYMBOLS; s++) begin
        freq[s] = '0;
        code_len[s] = 0;
      end
      for (int n = 0; n < hbe_pkg::NODES; n++) parent[n] = -1;
      acc_bits = '0;
      acc_count = 0;
      expected_words.delete();
      mismatches = 0;
    endfunction

    function int lightest(ref bit alive[hbe_pkg::NODES], input int limit);
      int best;
      best = -1;
      for (int i = 0; i < limit; i++)
        if (alive[i] && (best < 0 || weight[i] < weight[best])) best = i;
      return best;
    endfunction

    // Rebuild the code table from the current counts.
    function void build_table();
      bit alive[hbe_pkg::NODES];
      int next_node, a, b, len, cur, par;
      bit path[hbe_pkg::MAX_CODE];
      for (int i = 0; i < hbe_pkg::NODES; i++) alive[i] = 0;
      for (int s = 0; s < hbe_pkg::SYMBOLS; s++) begin
        weight[s] = hbe_pkg::WEIGHT_BITS'(freq[s]);
        alive[s] = 1;
      end
      next_node = hbe_pkg::SYMBOLS;
      for (int m = 0; m < hbe_pkg::SYMBOLS - 1 && next_node < hbe_pkg::NODES; m++) begin
        a = lightest(alive, next_node);
        if (a < 0) break;
        alive[a] = 0;
        b = lightest(alive, next_node);
        if (b < 0) begin
          alive[a] = 1;
          break;
        end
        alive[b] = 0;
        parent[a] = next_node;
        parent[b] = next_node;
        parent[next_node] = -1;
        first_child[next_node] = a;
        second_child[next_node] = b;
        weight[next_node] = weight[a] + weight[b];
        alive[next_node] = 1;
        next_node++;
      end
      // Walk each leaf up to the root, then reverse the path.
      for (int s = 0; s < hbe_pkg::SYMBOLS; s++) begin
        len = 0;
        cur = s;
        par = parent[s];
        while (par >= hbe_pkg::SYMBOLS && par < next_node && len < hbe_pkg::MAX_CODE) begin
          path[len] = (second_child[par] == cur);
          len++;
          cur = par;
          par = parent[cur];
        end
        code[s] = '0;
        for (int k = 0; k < len; k++) code[s][k] = path[len - 1 - k];
        code_len[s] = len;
      end
    endfunction

    // Note one accepted input word and queue the output words it causes.
    function void note(logic [1:0] cmd, logic [7:0] sym, logic eot);
      packed_word_t fresh[$];
      packed_word_t w;
      logic [7:0] full;
      case (cmd)
        hbe_pkg::CMD_COUNT: begin
          if (freq[sym] != '1) freq[sym] = freq[sym] + 1'b1;
        end
        hbe_pkg::CMD_BUILD: build_table();
        hbe_pkg::CMD_ENCODE: begin
          for (int k = 0; k < code_len[sym]; k++) begin
            full = {acc_bits, code[sym][k]};
            if (acc_count == hbe_pkg::BYTE_BITS - 1) begin
              w.word = full;
              w.last = 0;
              fresh.insert(fresh.size(), w);
              acc_bits = '0;
              acc_count = 0;
            end else begin
              acc_bits = full[6:0];
              acc_count++;
            end
          end
          if (eot && acc_count > 0) begin
            w.word = 8'({1'b0, acc_bits} << (hbe_pkg::BYTE_BITS - acc_count));
            w.last = 0;
            fresh.insert(fresh.size(), w);
            acc_bits = '0;
            acc_count = 0;
          end
        end
        default: ;
      endcase
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1;
      foreach (fresh[i]) expected_words.insert(expected_words.size(), fresh[i]);
    endfunction

    // Compare one output word with the oldest expectation.
    function void check(logic [7:0] word, logic last);
      packed_word_t w;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected word: packed_byte=%02h last_of_run=%0b", word, last);
        return;
      end
      w = expected_words.pop_front();
      if (word !== w.word || last !== w.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Word mismatch: expected %02h/%0b, got %02h/%0b",
                   w.word, w.last, word, last);
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [1:0] command_i;
  logic [7:0] symbol_i;
  logic       end_of_text_i;
  logic       result_valid_o;
  logic [7:0] packed_byte_o;
  logic       last_of_run_o;

  huffman_scoreboard coder;

  huffman_byte_encoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .symbol_i       (symbol_i),
    .end_of_text_i  (end_of_text_i),
    .result_valid_o (result_valid_o),
    .packed_byte_o  (packed_byte_o),
    .last_of_run_o  (last_of_run_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watch both handshakes at every rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) coder.note(command_i, symbol_i, end_of_text_i);
      if (result_valid_o) coder.check(packed_byte_o, last_of_run_o);
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Present one command word and hold it until the block takes it.
  task automatic send_word(logic [1:0] cmd, logic [7:0] sym, logic eot, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    command_i <= cmd;
    symbol_i <= sym;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic random_word();
    int pick;
    logic [7:0] sym;
    pick = $urandom_range(0, 99);
    // Skew the counted symbols so the built codes vary in length.
    sym = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    if (pick < 45) send_word(hbe_pkg::CMD_COUNT, sym, 1'($urandom), pick_gap());
    else if (pick < 95)
      send_word(hbe_pkg::CMD_ENCODE, 8'($urandom), ($urandom_range(0, 7) == 0), pick_gap());
    else send_word(CMD_UNUSED, 8'($urandom), 1'($urandom), pick_gap());
  endtask

  initial begin
    int wait_cycles;
    coder = new();
    coder.clear();
    start = 1'b0;
    command_i = hbe_pkg::CMD_COUNT;
    symbol_i = '0;
    end_of_text_i = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: encode before any build, end of text with nothing pending.
    send_word(hbe_pkg::CMD_ENCODE, 8'h00, 1'b1, 0);
    send_word(hbe_pkg::CMD_ENCODE, 8'hFF, 1'b0, 1);
    send_word(CMD_UNUSED, 8'hA5, 1'b1, 0);
    // Skewed counts at the symbol extremes, end_of_text on a count is ignored.
    for (int i = 0; i < 6; i++) send_word(hbe_pkg::CMD_COUNT, 8'h00, 1'b1, 0);
    for (int i = 0; i < 3; i++) send_word(hbe_pkg::CMD_COUNT, 8'hFF, 1'b0, 0);
    send_word(hbe_pkg::CMD_COUNT, 8'h80, 1'b0, 2);
    send_word(hbe_pkg::CMD_BUILD, 8'h5A, 1'b1, 0);
    // Short and long codes, then a flush of the partial word.
    send_word(hbe_pkg::CMD_ENCODE, 8'h00, 1'b0, 0);
    send_word(hbe_pkg::CMD_ENCODE, 8'h01, 1'b0, 0);
    send_word(hbe_pkg::CMD_ENCODE, 8'hFF, 1'b0, 3);
    send_word(hbe_pkg::CMD_ENCODE, 8'h7F, 1'b0, 0);
    send_word(hbe_pkg::CMD_ENCODE, 8'h80, 1'b1, 0);
    send_word(hbe_pkg::CMD_ENCODE, 8'h80, 1'b1, 0);

    // Random: counts, encodes and ignored words, with one rebuild in the middle.
    for (int i = 0; i < 200; i++) begin
      if (i == 100) send_word(hbe_pkg::CMD_BUILD, 8'($urandom), 1'($urandom), pick_gap());
      else random_word();
    end
    send_word(hbe_pkg::CMD_ENCODE, 8'($urandom), 1'b1, 0);
    start <= 1'b0;

    // Drain the remaining words, then allow a few quiet cycles.
    wait_cycles = 0;
    while (coder.expected_words.size() > 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (50) @(posedge clk_i);

    if (coder.mismatches == 0 && coder.expected_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run (the two full builds dominate).
  initial begin
    #50000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: huffman_byte_encoder.f
src/hbe_pkg.sv
src/hbe_ctrl.sv
src/hbe_datapath.sv
src/huffman_byte_encoder.sv
sim/huffman_byte_encoder_tb.sv
